// ===== design/sphere_pair_overlap_contact_unit_defines.svh =====
// assertion macros for the sphere pair overlap and contact unit
`ifndef SPHERE_PAIR_OVERLAP_CONTACT_UNIT_DEFINES_SVH
`define SPHERE_PAIR_OVERLAP_CONTACT_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPOC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPOC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spoc_pkg.sv =====
// package for the sphere pair overlap and contact unit: widths, side data, helpers
`timescale 1ns / 1ps
package spoc_pkg;

  localparam int COORD_W     = 32;
  localparam int RADIUS_W    = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int NORM_W      = 31;
  localparam int SQ_W        = 50;
  localparam int SUMSQ_W     = 64;
  localparam int ROOT_W      = 32;
  localparam int REM_W       = ROOT_W + 3;
  localparam int PROD_W      = NORM_W + RADIUS_W;
  localparam int QUOT_W      = RADIUS_W + 1;
  localparam int NUM_W       = PROD_W + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUOT_W;
  localparam int AXES        = 3;
  localparam int LANES       = 2 * AXES;
  localparam int AXIS_Y      = 1;
  localparam int FAR_BIT     = 25;

  // data that rides alongside the arithmetic from entry to exit
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] ca;
    logic [AXES-1:0][COORD_W-1:0] cb;
    logic [RADIUS_W-1:0]          ra;
    logic [RADIUS_W-1:0]          rb;
    logic [AXES-1:0]              neg;
    logic                         zero;
    logic                         ovl;
  } side_t;

  // left shift that brings the top set bit of a 31-bit word to bit 30
  function automatic logic [4:0] norm_shift(input logic [NORM_W-1:0] v);
    logic [4:0] c;
    c = 5'd0;
    for (int i = 0; i < NORM_W; i++) begin
      if (v[i]) c = 5'(NORM_W - 1 - i);
    end
    return c;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
    logic [COORD_W-1:0] r;
    if (v > $signed({3'b000, {(COORD_W-1){1'b1}}})) r = {1'b0, {(COORD_W-1){1'b1}}};
    else if (v < $signed({3'b111, {(COORD_W-1){1'b0}}})) r = {1'b1, {(COORD_W-1){1'b0}}};
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

// ===== design/sphere_pair_overlap_contact_unit.sv =====
// sphere pair overlap test with contact points, fully pipelined
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+-----------
//  in      | input     | in_centre_a/b_x/y/z, in_radius_a/b           | valid/ready
//  out     | output    | out_overlapping, out_contact_a/b_x/y/z       | valid/ready
//
// one transaction per cycle sustained while the output is not stalled; the pipe is
// the 32-stage square root (one root bit per stage) and the 25-stage divider
// (one quotient bit per stage) behind a five-stage front end
// synchronous active-low reset clears the valid bits only
// the whole pipe advances together: a stalled output freezes every stage,
// so a transaction is neither dropped nor repeated
`timescale 1ns / 1ps
`include "sphere_pair_overlap_contact_unit_defines.svh"

module sphere_pair_overlap_contact_unit import spoc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  in_centre_a_x,
  input  logic signed [COORD_W-1:0]  in_centre_a_y,
  input  logic signed [COORD_W-1:0]  in_centre_a_z,
  input  logic signed [COORD_W-1:0]  in_centre_b_x,
  input  logic signed [COORD_W-1:0]  in_centre_b_y,
  input  logic signed [COORD_W-1:0]  in_centre_b_z,
  input  logic [RADIUS_W-1:0]        in_radius_a,
  input  logic [RADIUS_W-1:0]        in_radius_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_overlapping,
  output logic signed [COORD_W-1:0]  out_contact_a_x,
  output logic signed [COORD_W-1:0]  out_contact_a_y,
  output logic signed [COORD_W-1:0]  out_contact_a_z,
  output logic signed [COORD_W-1:0]  out_contact_b_x,
  output logic signed [COORD_W-1:0]  out_contact_b_y,
  output logic signed [COORD_W-1:0]  out_contact_b_z
);

  // global advance: the output slot is empty or being emptied
  logic en;

  // stage 1: centre differences and magnitudes
  logic                          s1_vld_r;
  side_t                         s1_side_r, s1_side_nxt;
  logic [AXES-1:0][DIFF_W-1:0]   s1_mag_r, s1_mag_nxt;

  // stage 2: normalising shift, overlap squares
  logic                          s2_vld_r;
  side_t                         s2_side_r, s2_side_nxt;
  logic [AXES-1:0][DIFF_W-1:0]   s2_mag_r;
  logic [AXES-1:0][SQ_W-1:0]     s2_sq_r, s2_sq_nxt;
  logic [SQ_W-1:0]               s2_rs2_r, s2_rs2_nxt;
  logic                          s2_far_r, s2_far_nxt;
  logic                          s2_shr_r, s2_shr_nxt;
  logic [4:0]                    s2_shl_r, s2_shl_nxt;

  // stage 3: normalised magnitudes, overlap flag
  logic                          s3_vld_r;
  side_t                         s3_side_r, s3_side_nxt;
  logic [AXES-1:0][NORM_W-1:0]   s3_e_r, s3_e_nxt;

  // stage 4: squares and radius products
  logic                          s4_vld_r;
  side_t                         s4_side_r;
  logic [AXES-1:0][2*NORM_W-1:0] s4_ee_r, s4_ee_nxt;
  logic [LANES-1:0][PROD_W-1:0]  s4_p_r, s4_p_nxt;

  // square root pipe, index 0 is its entry register
  logic [SQRT_STAGES:0]                   sq_vld_r;
  side_t [SQRT_STAGES:0]                  sq_side_r;
  logic [SQRT_STAGES:0][SUMSQ_W-1:0]      sq_n_r;
  logic [SQRT_STAGES:0][REM_W-1:0]        sq_rem_r;
  logic [SQRT_STAGES:0][ROOT_W-1:0]       sq_root_r;
  logic [SQRT_STAGES:0][LANES-1:0][PROD_W-1:0] sq_p_r;

  // divider pipe, index 0 is its entry register
  logic [DIV_STAGES:0]                    dv_vld_r;
  side_t [DIV_STAGES:0]                   dv_side_r;
  logic [DIV_STAGES:0][ROOT_W-1:0]        dv_len_r;
  logic [DIV_STAGES:0][LANES-1:0][ROOT_W-1:0] dv_rem_r;
  logic [DIV_STAGES:0][LANES-1:0][QUOT_W-1:0] dv_low_r;
  logic [DIV_STAGES:0][LANES-1:0][QUOT_W-1:0] dv_q_r;

  // output register
  logic                             out_vld_r;
  logic                             out_ovl_r;
  logic [LANES-1:0][COORD_W-1:0]    out_coord_r, out_coord_nxt;

  assign en       = ~out_vld_r | out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    s1_side_nxt       = '0;
    s1_side_nxt.ca[0] = in_centre_a_x;
    s1_side_nxt.ca[1] = in_centre_a_y;
    s1_side_nxt.ca[2] = in_centre_a_z;
    s1_side_nxt.cb[0] = in_centre_b_x;
    s1_side_nxt.cb[1] = in_centre_b_y;
    s1_side_nxt.cb[2] = in_centre_b_z;
    s1_side_nxt.ra    = in_radius_a;
    s1_side_nxt.rb    = in_radius_b;
    for (int i = 0; i < AXES; i++) begin
      d = $signed({s1_side_nxt.cb[i][COORD_W-1], s1_side_nxt.cb[i]})
        - $signed({s1_side_nxt.ca[i][COORD_W-1], s1_side_nxt.ca[i]});
      s1_side_nxt.neg[i] = d[DIFF_W-1];
      s1_mag_nxt[i]      = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    logic [DIFF_W-1:0]   orm;
    logic [QUOT_W-1:0]   rs;
    orm = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    // the or of the magnitudes has the same top bit as their maximum
    s2_far_nxt       = |orm[DIFF_W-1:FAR_BIT];
    s2_shr_nxt       = orm[DIFF_W-1] | orm[DIFF_W-2];
    s2_shl_nxt       = norm_shift(orm[NORM_W-1:0]);
    s2_side_nxt      = s1_side_r;
    s2_side_nxt.zero = ~|orm;
    for (int i = 0; i < AXES; i++) begin
      s2_sq_nxt[i] = s1_mag_r[i][FAR_BIT-1:0] * s1_mag_r[i][FAR_BIT-1:0];
    end
    rs         = {1'b0, s1_side_r.ra} + {1'b0, s1_side_r.rb};
    s2_rs2_nxt = rs * rs;
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    logic [SQ_W+1:0] dist2;
    for (int i = 0; i < AXES; i++) begin
      s3_e_nxt[i] = s2_shr_r ? s2_mag_r[i][DIFF_W-2:1] : (s2_mag_r[i][NORM_W-1:0] << s2_shl_r);
    end
    dist2 = {2'b00, s2_sq_r[0]} + {2'b00, s2_sq_r[1]} + {2'b00, s2_sq_r[2]};
    s3_side_nxt     = s2_side_r;
    s3_side_nxt.ovl = ~s2_far_r & (dist2 <= {2'b00, s2_rs2_r});
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s4_ee_nxt[i]     = s3_e_r[i] * s3_e_r[i];
      s4_p_nxt[i]      = s3_e_r[i] * s3_side_r.ra;
      s4_p_nxt[AXES+i] = s3_e_r[i] * s3_side_r.rb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      sq_vld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r    <= s1_side_nxt;
      s1_mag_r     <= s1_mag_nxt;
      s2_side_r    <= s2_side_nxt;
      s2_mag_r     <= s1_mag_r;
      s2_sq_r      <= s2_sq_nxt;
      s2_rs2_r     <= s2_rs2_nxt;
      s2_far_r     <= s2_far_nxt;
      s2_shr_r     <= s2_shr_nxt;
      s2_shl_r     <= s2_shl_nxt;
      s3_side_r    <= s3_side_nxt;
      s3_e_r       <= s3_e_nxt;
      s4_side_r    <= s3_side_r;
      s4_ee_r      <= s4_ee_nxt;
      s4_p_r       <= s4_p_nxt;
      // stage 5: sum of squares enters the root pipe
      sq_side_r[0] <= s4_side_r;
      sq_n_r[0]    <= SUMSQ_W'(s4_ee_r[0]) + SUMSQ_W'(s4_ee_r[1]) + SUMSQ_W'(s4_ee_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_p_r[0]    <= s4_p_r;
    end
  end

  // ------------------------------------------------ square root, bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb begin
      rem_sh = {sq_rem_r[k][REM_W-3:0], sq_n_r[k][SUMSQ_W-1 -: 2]};
      trial  = {1'b0, sq_root_r[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_p_r[k+1]    <= sq_p_r[k];
        sq_n_r[k+1]    <= sq_n_r[k] << 2;
        sq_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], take};
      end
    end
  end

  // -------------------------------------- rounding bias, divider entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    if (en) begin
      dv_side_r[0] <= sq_side_r[SQRT_STAGES];
      dv_len_r[0]  <= sq_root_r[SQRT_STAGES];
      for (int j = 0; j < LANES; j++) begin
        // half the length added for round half up
        num = NUM_W'(sq_p_r[SQRT_STAGES][j]) + NUM_W'(sq_root_r[SQRT_STAGES][ROOT_W-1:1]);
        dv_rem_r[0][j] <= {1'b0, num[NUM_W-1:QUOT_W]};
        dv_low_r[0][j] <= num[QUOT_W-1:0];
        dv_q_r[0][j]   <= '0;
      end
    end
  end

  // ---------------------------------------- restoring divide, bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [LANES-1:0][ROOT_W:0]  rem_sh;
    logic [LANES-1:0]            take;

    always_comb begin
      for (int j = 0; j < LANES; j++) begin
        rem_sh[j] = {dv_rem_r[k][j], dv_low_r[k][j][QUOT_W-1]};
        take[j]   = rem_sh[j] >= {1'b0, dv_len_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_len_r[k+1]  <= dv_len_r[k];
        for (int j = 0; j < LANES; j++) begin
          dv_rem_r[k+1][j] <= take[j] ? ROOT_W'(rem_sh[j] - {1'b0, dv_len_r[k]})
                                      : rem_sh[j][ROOT_W-1:0];
          dv_low_r[k+1][j] <= dv_low_r[k][j] << 1;
          dv_q_r[k+1][j]   <= {dv_q_r[k][j][QUOT_W-2:0], take[j]};
        end
      end
    end
  end

  // ------------------------------------------- signed offsets, saturation
  always_comb begin
    side_t                   sd;
    logic [QUOT_W-1:0]       off;
    logic [COORD_W-1:0]      base;
    logic                    plus;
    logic signed [COORD_W+1:0] sum;
    sd = dv_side_r[DIV_STAGES];
    for (int j = 0; j < LANES; j++) begin
      if (sd.zero) begin
        // coincident centres: direction taken as +y
        if (j % AXES == AXIS_Y) off = (j >= AXES) ? {1'b0, sd.rb} : {1'b0, sd.ra};
        else off = '0;
      end else begin
        off = dv_q_r[DIV_STAGES][j];
      end
      base = (j >= AXES) ? sd.cb[j % AXES] : sd.ca[j % AXES];
      // a moves toward b, b moves toward a
      plus = (j >= AXES) ? sd.neg[j % AXES] : ~sd.neg[j % AXES];
      sum  = plus ? $signed({{2{base[COORD_W-1]}}, base}) + $signed({9'b0, off})
                  : $signed({{2{base[COORD_W-1]}}, base}) - $signed({9'b0, off});
      out_coord_nxt[j] = sat_coord(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ovl_r   <= dv_side_r[DIV_STAGES].ovl;
      out_coord_r <= out_coord_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_overlapping = out_ovl_r;
  assign out_contact_a_x = out_coord_r[0];
  assign out_contact_a_y = out_coord_r[1];
  assign out_contact_a_z = out_coord_r[2];
  assign out_contact_b_x = out_coord_r[3];
  assign out_contact_b_y = out_coord_r[4];
  assign out_contact_b_z = out_coord_r[5];

  // ------------------------------------------------------------ assertions
  // a stall freezes the valid bits of the root and divider pipes
  `SPOC_ASSERT_NEXT(a_stall_holds, !en, $stable(sq_vld_r) && $stable(dv_vld_r), "pipe moved during stall")
  // normalisation leaves the length in the top two bits
  `SPOC_ASSERT_NOW(a_root_norm, dv_vld_r[0] && !dv_side_r[0].zero, dv_len_r[0][ROOT_W-1] || dv_len_r[0][ROOT_W-2], "length not normalised")
  // an x offset never exceeds its radius
  `SPOC_ASSERT_NOW(a_quot_bound, dv_vld_r[DIV_STAGES] && !dv_side_r[DIV_STAGES].zero, dv_q_r[DIV_STAGES][0] <= {1'b0, dv_side_r[DIV_STAGES].ra} && dv_q_r[DIV_STAGES][3] <= {1'b0, dv_side_r[DIV_STAGES].rb}, "offset beyond radius")
  // coincident centres always overlap
  `SPOC_ASSERT_NOW(a_zero_ovl, dv_vld_r[DIV_STAGES] && dv_side_r[DIV_STAGES].zero, dv_side_r[DIV_STAGES].ovl, "coincident centres without overlap")

endmodule

// ===== sim/sphere_pair_overlap_contact_unit_test.sv =====
// self-checking testbench for the sphere pair overlap and contact unit
`timescale 1ns / 1ps

module sphere_pair_overlap_contact_unit_test;
  import spoc_pkg::*;

  // one sphere pair as offered on the input channel
  typedef struct {
    logic signed [COORD_W-1:0] ca [3];
    logic signed [COORD_W-1:0] cb [3];
    logic [RADIUS_W-1:0]       ra;
    logic [RADIUS_W-1:0]       rb;
  } sphere_pair_t;

  // overlap flag and the two contact points
  typedef struct {
    logic                      overlapping;
    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
  } contact_t;

  localparam int MAX_GAP     = 18;
  localparam int LATENCY     = 64;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_centre_a_x = '0, in_centre_a_y = '0, in_centre_a_z = '0;
  logic signed [COORD_W-1:0] in_centre_b_x = '0, in_centre_b_y = '0, in_centre_b_z = '0;
  logic [RADIUS_W-1:0] in_radius_a = '0, in_radius_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_overlapping;
  logic signed [COORD_W-1:0] out_contact_a_x, out_contact_a_y, out_contact_a_z;
  logic signed [COORD_W-1:0] out_contact_b_x, out_contact_b_y, out_contact_b_z;

  contact_t pending_contacts [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  // idling controls for the sender and the receiver
  bit       sender_busy_mode = 1'b0;
  bit       receiver_busy_mode = 1'b0;
  int       receiver_hold = 0;

  sphere_pair_overlap_contact_unit DUT (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_centre_a_x, .in_centre_a_y, .in_centre_a_z,
    .in_centre_b_x, .in_centre_b_y, .in_centre_b_z,
    .in_radius_a, .in_radius_b,
    .out_valid, .out_ready,
    .out_overlapping,
    .out_contact_a_x, .out_contact_a_y, .out_contact_a_z,
    .out_contact_b_x, .out_contact_b_y, .out_contact_b_z
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[COORD_W-1:0];
  endfunction

  // expected flag and contact points for one pair
  function automatic contact_t predict_contact(sphere_pair_t p);
    contact_t r;
    longint signed a [3], b [3], d [3];
    longint unsigned mag [3], e [3];
    longint unsigned maxm, dist_sq, rsum, len, half;
    longint signed oa, ob;
    int shl;
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = p.ca[i];
      b[i] = p.cb[i];
      d[i] = b[i] - a[i];
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm >= (64'd1 << 25)) begin
      r.overlapping = 1'b0;
    end else begin
      dist_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      rsum = longint'(p.ra) + longint'(p.rb);
      r.overlapping = (dist_sq <= rsum * rsum);
    end
    if (maxm == 0) begin
      // coincident centres: fixed direction along +y
      for (int i = 0; i < 3; i++) begin
        oa = (i == 1) ? longint'(p.ra) : 0;
        ob = (i == 1) ? longint'(p.rb) : 0;
        r.pa[i] = clamp_coord(a[i] + oa);
        r.pb[i] = clamp_coord(b[i] - ob);
      end
      return r;
    end
    shl = 0;
    if (maxm < (64'd1 << 31)) begin
      while ((maxm << shl) < (64'd1 << 30)) shl++;
    end
    for (int i = 0; i < 3; i++)
      e[i] = (maxm >= (64'd1 << 31)) ? (mag[i] >> 1) : (mag[i] << shl);
    len = int_sqrt(e[0] * e[0] + e[1] * e[1] + e[2] * e[2]);
    half = len >> 1;
    for (int i = 0; i < 3; i++) begin
      oa = (e[i] * p.ra + half) / len;
      ob = (e[i] * p.rb + half) / len;
      if (d[i] < 0) begin
        oa = -oa;
        ob = -ob;
      end
      r.pa[i] = clamp_coord(a[i] + oa);
      r.pb[i] = clamp_coord(b[i] - ob);
    end
    return r;
  endfunction

  // offers one pair and waits until it is accepted
  task automatic send_pair(sphere_pair_t p);
    int gap;
    gap = sender_busy_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_centre_a_x <= p.ca[0];
    in_centre_a_y <= p.ca[1];
    in_centre_a_z <= p.ca[2];
    in_centre_b_x <= p.cb[0];
    in_centre_b_y <= p.cb[1];
    in_centre_b_z <= p.cb[2];
    in_radius_a <= p.ra;
    in_radius_b <= p.rb;
    do @(posedge clk); while (!in_ready);
    pending_contacts.push_back(predict_contact(p));
  endtask

  function automatic sphere_pair_t make_pair(logic signed [31:0] ax, ay, az, bx, by, bz,
                                             logic [23:0] ra, rb);
    sphere_pair_t p;
    p.ca[0] = ax; p.ca[1] = ay; p.ca[2] = az;
    p.cb[0] = bx; p.cb[1] = by; p.cb[2] = bz;
    p.ra = ra; p.rb = rb;
    return p;
  endfunction

  // radius with a random magnitude so small and large values both occur
  function automatic logic [RADIUS_W-1:0] random_radius();
    return RADIUS_W'($urandom >> $urandom_range(8, 31));
  endfunction

  // pair whose centres sit within reach of the radii, so both flag values appear
  function automatic sphere_pair_t random_near_pair();
    sphere_pair_t p;
    int span;
    p.ra = random_radius();
    p.rb = random_radius();
    span = $urandom_range(0, 26);
    for (int i = 0; i < 3; i++) begin
      p.ca[i] = $urandom;
      p.cb[i] = p.ca[i] + ($signed($urandom) >>> (31 - span));
    end
    // now and then a b axis set to a's x coordinate, or coincident centres
    if ($urandom_range(0, 9) == 0) p.cb[$urandom_range(0, 2)] = p.ca[0];
    if ($urandom_range(0, 29) == 0) p.cb = p.ca;
    return p;
  endfunction

  function automatic sphere_pair_t random_wide_pair();
    sphere_pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.ca[i] = $urandom;
      p.cb[i] = $urandom;
    end
    p.ra = RADIUS_W'($urandom);
    p.rb = RADIUS_W'($urandom);
    return p;
  endfunction

  // result side: random stalls, a long hold when asked, one check per transaction
  initial begin
    contact_t exp_c;
    int stall;
    @(posedge rst_n);
    forever begin
      if (receiver_hold > 0) begin
        stall = receiver_hold;
        receiver_hold = 0;
      end else begin
        stall = receiver_busy_mode ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_contacts.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        mismatches++;
      end else begin
        exp_c = pending_contacts.pop_front();
        if (out_overlapping !== exp_c.overlapping) begin
          $display("%0t: overlapping expected %0d actual %0d", $realtime,
                   exp_c.overlapping, out_overlapping);
          mismatches++;
        end
        if (out_contact_a_x !== exp_c.pa[0] || out_contact_a_y !== exp_c.pa[1] ||
            out_contact_a_z !== exp_c.pa[2]) begin
          $display("%0t: contact a expected (%0d %0d %0d) actual (%0d %0d %0d)", $realtime,
                   exp_c.pa[0], exp_c.pa[1], exp_c.pa[2],
                   out_contact_a_x, out_contact_a_y, out_contact_a_z);
          mismatches++;
        end
        if (out_contact_b_x !== exp_c.pb[0] || out_contact_b_y !== exp_c.pb[1] ||
            out_contact_b_z !== exp_c.pb[2]) begin
          $display("%0t: contact b expected (%0d %0d %0d) actual (%0d %0d %0d)", $realtime,
                   exp_c.pb[0], exp_c.pb[1], exp_c.pb[2],
                   out_contact_b_x, out_contact_b_y, out_contact_b_z);
          mismatches++;
        end
      end
    end
  end

  // corner cases: coincidence, far apart, extremes, saturation, rounding
  task automatic test_directed();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 24'd0, 24'd0));
    send_pair(make_pair(100, -5, 7, 100, -5, 7, 24'hffffff, 24'hffffff));
    send_pair(make_pair(0, 32'sh7fff0000, 0, 0, 32'sh7fff0000, 0, 24'hffffff, 24'h1));
    send_pair(make_pair(0, 32'sh80000000, 0, 0, 32'sh80000000, 0, 24'h0, 24'hffffff));
    send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 24'hffffff));
    send_pair(make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hffffff, 24'hffffff));
    send_pair(make_pair(0, 0, 0, 32'sd1 <<< 25, 0, 0, 24'hffffff, 24'hffffff));
    send_pair(make_pair(0, 0, 0, (32'sd1 <<< 25) - 1, 0, 0, 24'hffffff, 24'hffffff));
    send_pair(make_pair(0, 0, 0, 0, 0, -(32'sd1 <<< 25), 24'h800000, 24'h800000));
    send_pair(make_pair(0, 0, 0, 1, 0, 0, 24'd0, 24'd0));
    send_pair(make_pair(0, 0, 0, -1, -1, -1, 24'h10000, 24'h10000));
    send_pair(make_pair(0, 0, 0, 3, 4, 0, 24'd2, 24'd3));
    send_pair(make_pair(0, 0, 0, 3, 4, 0, 24'd2, 24'd2));
    send_pair(make_pair(5, 5, 5, 5, 5, 5 + 24'hffffff, 24'h7fffff, 24'h800000));
    send_pair(make_pair(32'sh7fffff00, 0, 0, 32'sh7fffff00 - 1000, 0, 0,
                        24'hffffff, 24'hffffff));
    send_pair(make_pair(32'sh80000100, 0, 0, 32'sh80000100 + 1000, 0, 0,
                        24'hffffff, 24'hffffff));
    send_pair(make_pair(1, 2, 3, 1 + 32'sh40000000, 2, 3, 24'h123456, 24'h654321));
    send_pair(make_pair(0, 0, 0, 32'sh7fffffff, 1, 1, 24'haaaaaa, 24'h555555));
  endtask

  task automatic test_random_near(int count);
    repeat (count) send_pair(random_near_pair());
  endtask

  task automatic test_random_wide(int count);
    repeat (count) send_pair(random_wide_pair());
  endtask

  // results held back while the sender keeps offering, so the pipe fills and stalls
  task automatic test_backpressure();
    sender_busy_mode = 1'b1;
    receiver_hold = 400;
    repeat (200) send_pair(random_near_pair());
    sender_busy_mode = 1'b0;
  endtask

  // a stretch with neither side idling
  task automatic test_full_rate();
    sender_busy_mode = 1'b1;
    receiver_busy_mode = 1'b1;
    repeat (150) send_pair(random_near_pair());
    sender_busy_mode = 1'b0;
    receiver_busy_mode = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_near(700);
    test_backpressure();
    test_random_wide(250);
    test_full_rate();
    test_random_near(200);
    in_valid <= 1'b0;
    wait (pending_contacts.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
